>>> sv/rttb_pkg.sv
// Shared types, codes and character helpers for the radix text to byte decoder.
`timescale 1ns / 1ps
`default_nettype none
package rttb_pkg;

  localparam int TOKEN_BUFFER = 256;
  localparam int TOK_LEN_W    = $clog2(TOKEN_BUFFER);
  localparam int ACC_W        = 10;

  // Radix modes.
  localparam logic [1:0] MODE_HEX = 2'd0;
  localparam logic [1:0] MODE_BIN = 2'd1;
  localparam logic [1:0] MODE_OCT = 2'd2;
  localparam logic [1:0] MODE_DEC = 2'd3;

  // Status codes.
  localparam logic [3:0] ST_OK       = 4'd0;
  localparam logic [3:0] ST_END      = 4'd1;
  localparam logic [3:0] ST_BADCHAR  = 4'd2;
  localparam logic [3:0] ST_RANGE    = 4'd3;
  localparam logic [3:0] ST_ODDHEX   = 4'd4;
  localparam logic [3:0] ST_PARTBIN  = 4'd5;
  localparam logic [3:0] ST_OCTGROUP = 4'd6;
  localparam logic [3:0] ST_LONGDEC  = 4'd7;
  localparam logic [3:0] ST_TOOLONG  = 4'd8;

  // Character codes.
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_COMMA = 8'h2C;
  localparam logic [7:0] CH_SEMI  = 8'h3B;
  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_BAR   = 8'h7C;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_ONE   = 8'h31;
  localparam logic [7:0] CH_SEVEN = 8'h37;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_LA    = 8'h61;
  localparam logic [7:0] CH_LF    = 8'h66;
  localparam logic [7:0] CH_UA    = 8'h41;
  localparam logic [7:0] CH_UF    = 8'h46;

  typedef struct packed {
    logic                 nibble_pending;
    logic [ACC_W-1:0]     acc;
    logic [2:0]           bit_count;
    logic [1:0]           group_cnt;
    logic [TOK_LEN_W-1:0] tok_count;
    logic                 error_latched;
  } dec_state_t;

  typedef struct packed {
    logic       byte_valid;
    logic [7:0] byte_value;
    logic [3:0] status;
  } res_t;

  function automatic logic is_separator(input logic [7:0] c);
    return c inside {CH_SPACE, [CH_TAB:CH_CR], CH_COMMA, CH_SEMI, CH_COLON, CH_BAR};
  endfunction

  // Returns {valid, nibble}.
  function automatic logic [4:0] nibble_of(input logic [7:0] c);
    logic [7:0] d;
    d = 8'd0;
    if (c inside {[CH_ZERO:CH_NINE]}) begin
      d = c - CH_ZERO;
      return {1'b1, d[3:0]};
    end else if (c inside {[CH_LA:CH_LF]}) begin
      d = c - CH_LA + 8'd10;
      return {1'b1, d[3:0]};
    end else if (c inside {[CH_UA:CH_UF]}) begin
      d = c - CH_UA + 8'd10;
      return {1'b1, d[3:0]};
    end
    return 5'd0;
  endfunction

endpackage
`default_nettype wire

>>> sv/rttb_in_if.sv
// Input channel: one text character or end-of-stream mark per item.
`timescale 1ns / 1ps
`default_nettype none
interface rttb_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_code;
  logic       end_of_stream;

  modport source (output valid, output char_code, output end_of_stream, input ready);
  modport sink (input valid, input char_code, input end_of_stream, output ready);
endinterface
`default_nettype wire

>>> sv/rttb_out_if.sv
// Output channel: one decoded byte and status per item.
`timescale 1ns / 1ps
`default_nettype none
interface rttb_out_if;
  logic       valid;
  logic       ready;
  logic       byte_valid;
  logic [7:0] byte_value;
  logic [3:0] status;

  modport source (output valid, output byte_valid, output byte_value, output status,
                  input ready);
  modport sink (input valid, input byte_valid, input byte_value, input status,
                output ready);
endinterface
`default_nettype wire

>>> sv/rttb_cfg_if.sv
// Configuration write channel carrying the radix mode register.
`timescale 1ns / 1ps
`default_nettype none
interface rttb_cfg_if;
  logic       valid;
  logic       ready;
  logic [1:0] radix_mode;

  modport source (output valid, output radix_mode, input ready);
  modport sink (input valid, input radix_mode, output ready);
endinterface
`default_nettype wire

>>> sv/radix_text_to_byte_decoder_core.sv
// Top level: turns hex, binary, octal or decimal text back into bytes.
// Path: an item passes through the input register and then the result register.
// Throughput: one item per cycle while dout is not stalled, set by the input register and the result register.
// A stalled dout holds the input register once it is full and then backpressures din.
// Reset (rst, synchronous) selects hex mode and clears token state and the error latch.
// After an error the block drops all further items without result until reset.
`timescale 1ns / 1ps
`default_nettype none
module radix_text_to_byte_decoder_core (
  input wire logic   clk,
  input wire logic   rst,
  rttb_cfg_if.sink   cfg,
  rttb_in_if.sink    din,
  rttb_out_if.source dout
);
  import rttb_pkg::*;

  logic [1:0] radix_mode;
  dec_state_t state;
  dec_state_t state_next;
  dec_state_t state_cleared;
  logic       stage_valid;
  logic [7:0] stage_char;
  logic       stage_eos;
  logic       stage_fire;
  logic       out_free;
  logic       res_valid;
  res_t       res;
  logic       cfg_fire;
  res_t       out_data;

  // A mode write waits until the input register holds no item.
  assign cfg.ready  = !stage_valid;
  assign cfg_fire   = cfg.valid && cfg.ready;
  assign stage_fire = stage_valid && out_free;
  assign din.ready  = !stage_valid || stage_fire;

  always_ff @(posedge clk) begin
    if (rst) begin
      radix_mode <= MODE_HEX;
    end else if (cfg_fire) begin
      radix_mode <= cfg.radix_mode;
    end
  end

  // A mode write restarts the token but keeps a latched error.
  always_comb begin
    state_cleared               = '0;
    state_cleared.error_latched = state.error_latched;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= '0;
    end else if (cfg_fire) begin
      state <= state_cleared;
    end else if (stage_fire) begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (din.ready) begin
      stage_valid <= din.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (din.ready && din.valid) begin
      stage_char <= din.char_code;
      stage_eos  <= din.end_of_stream;
    end
  end

  rttb_step u_step (
    .mode          (radix_mode),
    .char_code     (stage_char),
    .end_of_stream (stage_eos),
    .cur           (state),
    .nxt           (state_next),
    .res_valid     (res_valid),
    .res           (res)
  );

  rttb_out_reg u_out (
    .clk       (clk),
    .rst       (rst),
    .load      (stage_fire && res_valid),
    .load_data (res),
    .take      (dout.ready),
    .free      (out_free),
    .valid     (dout.valid),
    .data      (out_data)
  );

  assign dout.byte_valid = out_data.byte_valid;
  assign dout.byte_value = out_data.byte_value;
  assign dout.status     = out_data.status;

  a_error_latches: assert property (@(posedge clk) disable iff (rst)
    (stage_fire && res_valid && res.status >= ST_BADCHAR) |=> state.error_latched)
    else $error("error result did not latch the error flag");

  a_error_sticky: assert property (@(posedge clk) disable iff (rst)
    state.error_latched |=> state.error_latched)
    else $error("error latch cleared without reset");

  a_silent_after_error: assert property (@(posedge clk) disable iff (rst)
    (stage_fire && state.error_latched) |-> !res_valid)
    else $error("result produced after an error was latched");

  a_byte_status: assert property (@(posedge clk) disable iff (rst)
    (dout.valid && dout.byte_valid) |-> (dout.status == ST_OK || dout.status == ST_END))
    else $error("decoded byte carries an error status");

  a_cfg_clears_token: assert property (@(posedge clk) disable iff (rst)
    cfg_fire |=> (state.tok_count == '0 && !state.nibble_pending && state.bit_count == 3'd0))
    else $error("mode write did not clear the token state");
endmodule
`default_nettype wire

>>> sv/rttb_step.sv
// Per-character decode logic: next token state and the result of one item.
`timescale 1ns / 1ps
`default_nettype none
module rttb_step (
  input  wire logic [1:0]          mode,
  input  wire logic [7:0]          char_code,
  input  wire logic                end_of_stream,
  input  wire rttb_pkg::dec_state_t cur,
  output rttb_pkg::dec_state_t     nxt,
  output logic                     res_valid,
  output rttb_pkg::res_t           res
);
  import rttb_pkg::*;

  logic             tok_mode;
  logic             close_err;
  logic [3:0]       close_code;
  logic             close_have;
  logic [7:0]       close_byte;
  logic [4:0]       nib;
  logic [7:0]       digit;
  logic [ACC_W-1:0] oct_acc;
  logic [13:0]      dec_wide;
  logic [ACC_W-1:0] bin_acc;
  logic             fail;
  logic [3:0]       fail_code;

  assign tok_mode = (mode == MODE_OCT) || (mode == MODE_DEC);
  assign nib      = nibble_of(char_code);
  assign digit    = char_code - CH_ZERO;
  assign bin_acc  = {cur.acc[ACC_W-2:0], digit[0]};
  assign oct_acc  = {cur.acc[ACC_W-4:0], digit[2:0]};
  assign dec_wide = {1'b0, cur.acc, 3'b000} + {3'b000, cur.acc, 1'b0} + {10'd0, digit[3:0]};

  // Outcome of closing an octal or decimal token.
  always_comb begin
    close_err  = 1'b0;
    close_code = ST_OK;
    close_have = 1'b0;
    close_byte = 8'd0;
    if (tok_mode && cur.tok_count != '0) begin
      if (mode == MODE_OCT) begin
        if (cur.group_cnt != 2'd0) begin
          if (cur.tok_count < TOK_LEN_W'(3)) begin
            close_have = 1'b1;
            close_byte = cur.acc[7:0];
          end else begin
            close_err  = 1'b1;
            close_code = ST_OCTGROUP;
          end
        end
      end else if (cur.acc > ACC_W'(255)) begin
        close_err  = 1'b1;
        close_code = ST_RANGE;
      end else begin
        close_have = 1'b1;
        close_byte = cur.acc[7:0];
      end
    end
  end

  always_comb begin
    nxt       = cur;
    res_valid = 1'b0;
    res       = '0;
    fail      = 1'b0;
    fail_code = ST_OK;
    if (!cur.error_latched) begin
      if (end_of_stream) begin
        case (mode)
          MODE_HEX: begin
            fail      = cur.nibble_pending;
            fail_code = ST_ODDHEX;
          end
          MODE_BIN: begin
            fail      = (cur.bit_count != 3'd0);
            fail_code = ST_PARTBIN;
          end
          default: begin
            fail      = close_err;
            fail_code = close_code;
          end
        endcase
        if (!fail) begin
          nxt                = '0;
          res_valid          = 1'b1;
          res.byte_valid     = close_have;
          res.byte_value     = close_byte;
          res.status         = ST_END;
        end
      end else if (is_separator(char_code)) begin
        if (tok_mode) begin
          fail      = close_err;
          fail_code = close_code;
          nxt.acc       = '0;
          nxt.group_cnt = 2'd0;
          nxt.tok_count = '0;
          if (!close_err && close_have) begin
            res_valid      = 1'b1;
            res.byte_valid = 1'b1;
            res.byte_value = close_byte;
            res.status     = ST_OK;
          end
        end
      end else begin
        case (mode)
          MODE_HEX: begin
            if (!nib[4]) begin
              fail      = 1'b1;
              fail_code = ST_BADCHAR;
            end else if (!cur.nibble_pending) begin
              nxt.acc            = ACC_W'(nib[3:0]);
              nxt.nibble_pending = 1'b1;
            end else begin
              nxt.acc            = '0;
              nxt.nibble_pending = 1'b0;
              res_valid          = 1'b1;
              res.byte_valid     = 1'b1;
              res.byte_value     = {cur.acc[3:0], nib[3:0]};
            end
          end
          MODE_BIN: begin
            if (char_code != CH_ZERO && char_code != CH_ONE) begin
              fail      = 1'b1;
              fail_code = ST_BADCHAR;
            end else if (cur.bit_count == 3'd7) begin
              nxt.acc        = '0;
              nxt.bit_count  = 3'd0;
              res_valid      = 1'b1;
              res.byte_valid = 1'b1;
              res.byte_value = bin_acc[7:0];
            end else begin
              nxt.acc       = bin_acc;
              nxt.bit_count = cur.bit_count + 3'd1;
            end
          end
          MODE_OCT: begin
            if (cur.tok_count >= TOK_LEN_W'(TOKEN_BUFFER - 1)) begin
              fail      = 1'b1;
              fail_code = ST_TOOLONG;
            end else if (!(char_code inside {[CH_ZERO:CH_SEVEN]})) begin
              fail      = 1'b1;
              fail_code = ST_BADCHAR;
            end else begin
              nxt.tok_count = cur.tok_count + TOK_LEN_W'(1);
              if (cur.group_cnt == 2'd2) begin
                // Every third digit completes a group that leaves at once.
                nxt.acc       = '0;
                nxt.group_cnt = 2'd0;
                if (oct_acc > ACC_W'(255)) begin
                  fail      = 1'b1;
                  fail_code = ST_RANGE;
                end else begin
                  res_valid      = 1'b1;
                  res.byte_valid = 1'b1;
                  res.byte_value = oct_acc[7:0];
                end
              end else begin
                nxt.acc       = oct_acc;
                nxt.group_cnt = cur.group_cnt + 2'd1;
              end
            end
          end
          default: begin
            if (cur.tok_count >= TOK_LEN_W'(TOKEN_BUFFER - 1)) begin
              fail      = 1'b1;
              fail_code = ST_TOOLONG;
            end else if (!(char_code inside {[CH_ZERO:CH_NINE]})) begin
              fail      = 1'b1;
              fail_code = ST_BADCHAR;
            end else if (cur.tok_count >= TOK_LEN_W'(3)) begin
              fail      = 1'b1;
              fail_code = ST_LONGDEC;
            end else begin
              nxt.tok_count = cur.tok_count + TOK_LEN_W'(1);
              nxt.acc       = dec_wide[ACC_W-1:0];
            end
          end
        endcase
      end
      if (fail) begin
        nxt.error_latched = 1'b1;
        res_valid         = 1'b1;
        res.byte_valid    = 1'b0;
        res.byte_value    = 8'd0;
        res.status        = fail_code;
      end
    end
  end
endmodule
`default_nettype wire

>>> sv/rttb_out_reg.sv
// Result register that holds one finished item until the sink takes it.
`timescale 1ns / 1ps
`default_nettype none
module rttb_out_reg (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           load,
  input  wire rttb_pkg::res_t load_data,
  input  wire logic           take,
  output logic                free,
  output logic                valid,
  output rttb_pkg::res_t      data
);
  import rttb_pkg::*;

  assign free = !valid || take;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (free) begin
      valid <= load;
    end
  end

  always_ff @(posedge clk) begin
    if (free && load) begin
      data <= load_data;
    end
  end
endmodule
`default_nettype wire
